>>> sv/bfbp_pkg.sv
// shared types and codes for the best-fit buffer pool
package bfbp_pkg;

  localparam int HANDLE_W = 16;
  localparam int CAP_W    = 24;

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_RETURN  = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] KIND_POOLED  = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_FREED   = 2'd2;
  localparam logic [1:0] KIND_NOTHING = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [CAP_W-1:0]    request_size;
    logic [HANDLE_W-1:0] returned_handle;
    logic [CAP_W-1:0]    returned_capacity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [HANDLE_W-1:0] out_handle;
    logic [CAP_W-1:0]    out_capacity;
    logic                last_result;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CAP_W-1:0]    capacity;
  } entry_t;

endpackage

>>> sv/bfbp_store.sv
// pool entry memory: one write port, one read port with registered read data
module bfbp_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output bfbp_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  bfbp_pkg::entry_t wr_data
);
  import bfbp_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/best_fit_buffer_pool_unit.sv
// best-fit buffer pool: ordered idle-buffer list kept in a memory, front at entry 0
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | in_item_t (action, size, returned buffer)
//   result  | out_valid, out_stall, out_data | out_item_t (kind, handle, capacity, last)
//
// one item at a time; steps from input transfer to result loaded:
// request: scan the pool; on a hit, then close up the entries behind the hit
// return: shift-up sweep, entry 0 written last (only entry 0 written on an empty pool)
// clear: read, then output each entry; empty-pool request, empty clear, action 3: emit
// in_stall is high from a transfer until its last result is in the output register
// out_stall pauses the block only when it has a new result; reset empties the pool
module best_fit_buffer_pool_unit #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bfbp_pkg::out_item_t out_data
);
  import bfbp_pkg::*;

  localparam int AW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CW = $clog2(MAX_BUFFERS + 1);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_BUFFERS);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_BUFFERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_REMOVE, ST_SHIFT, ST_CLR_RD, ST_CLR_OUT, ST_EMIT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   idx_r;
  logic [CW-1:0]   pos_r;
  logic [CW-1:0]   best_r;
  logic            pend_r;
  logic            have_r;
  logic            exact_r;
  in_item_t        item_r;
  logic [1:0]      res_kind_r;
  logic [HANDLE_W-1:0] res_h_r;
  logic [CAP_W-1:0]    res_c_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   pos_inc;
  logic [CW-1:0]   pos_dec;
  logic [CW-1:0]   best_inc;
  logic            idx_below;
  logic            out_free;
  logic            out_load;
  logic            in_xfer;

  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign pos_inc   = pos_r + 1'b1;
  assign pos_dec   = pos_r - 1'b1;
  assign best_inc  = best_r + 1'b1;
  assign idx_below = (idx_r < cnt_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && (state_r == ST_EMIT || state_r == ST_CLR_OUT);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  bfbp_store #(
    .DEPTH (MAX_BUFFERS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos_dec[AW-1:0];
    wr_data = rd_data;
    unique case (state_r)
      ST_SCAN: begin
        rd_en = idx_below;
      end
      ST_REMOVE: begin
        // close up: entry j moves to j-1
        rd_en = idx_below;
        wr_en = pend_r;
      end
      ST_SHIFT: begin
        // open entry 0: entry j moves to j+1, back entry of a full pool is evicted
        rd_en   = (idx_r != '0);
        rd_addr = idx_dec[AW-1:0];
        if (pend_r) begin
          wr_en   = (pos_r != LAST_C);
          wr_addr = pos_inc[AW-1:0];
        end else if (idx_r == '0) begin
          wr_en            = 1'b1;
          wr_addr          = '0;
          wr_data.handle   = item_r.returned_handle;
          wr_data.capacity = item_r.returned_capacity;
        end
      end
      ST_CLR_RD: begin
        rd_en = 1'b1;
      end
      ST_IDLE, ST_CLR_OUT, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      best_r      <= '0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      exact_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            item_r     <= in_data;
            idx_r      <= '0;
            pend_r     <= 1'b0;
            have_r     <= 1'b0;
            exact_r    <= 1'b0;
            res_kind_r <= KIND_NOTHING;
            res_h_r    <= '0;
            res_c_r    <= '0;
            unique case (in_data.action)
              ACT_REQUEST: begin
                if (cnt_r == '0) begin
                  res_kind_r <= KIND_ALLOC;
                  res_c_r    <= in_data.request_size;
                  state_r    <= ST_EMIT;
                end else begin
                  state_r <= ST_SCAN;
                end
              end
              ACT_RETURN: begin
                idx_r   <= cnt_r;
                state_r <= ST_SHIFT;
              end
              ACT_CLEAR: begin
                state_r <= (cnt_r == '0) ? ST_EMIT : ST_CLR_RD;
              end
              default: begin
                state_r <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          pend_r <= idx_below;
          pos_r  <= idx_r;
          if (idx_below) begin
            idx_r <= idx_inc;
          end
          if (pend_r && !exact_r) begin
            // exact size locks the choice, else keep the earliest smallest larger one
            if (rd_data.capacity == item_r.request_size) begin
              exact_r <= 1'b1;
              have_r  <= 1'b1;
              best_r  <= pos_r;
              res_h_r <= rd_data.handle;
              res_c_r <= rd_data.capacity;
            end else if (rd_data.capacity > item_r.request_size &&
                         (!have_r || rd_data.capacity < res_c_r)) begin
              have_r  <= 1'b1;
              best_r  <= pos_r;
              res_h_r <= rd_data.handle;
              res_c_r <= rd_data.capacity;
            end
          end
          if (!idx_below && !pend_r) begin
            if (have_r) begin
              res_kind_r <= KIND_POOLED;
              idx_r      <= best_inc;
              state_r    <= ST_REMOVE;
            end else begin
              res_kind_r <= KIND_ALLOC;
              res_h_r    <= '0;
              res_c_r    <= item_r.request_size;
              state_r    <= ST_EMIT;
            end
          end
        end
        ST_REMOVE: begin
          pend_r <= idx_below;
          pos_r  <= idx_r;
          if (idx_below) begin
            idx_r <= idx_inc;
          end
          if (!idx_below && !pend_r) begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= ST_EMIT;
          end
        end
        ST_SHIFT: begin
          pend_r <= (idx_r != '0);
          pos_r  <= idx_dec;
          if (idx_r != '0) begin
            idx_r <= idx_dec;
          end
          if (pend_r && pos_r == LAST_C) begin
            res_kind_r <= KIND_FREED;
            res_h_r    <= rd_data.handle;
            res_c_r    <= rd_data.capacity;
          end
          if (idx_r == '0 && !pend_r) begin
            // entry 0 takes the returned buffer this cycle
            if (cnt_r != MAX_C) begin
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= ST_EMIT;
          end
        end
        ST_CLR_RD: begin
          state_r <= ST_CLR_OUT;
        end
        ST_CLR_OUT: begin
          if (out_free) begin
            out_valid_r              <= 1'b1;
            out_data_r.result_kind   <= KIND_FREED;
            out_data_r.out_handle    <= rd_data.handle;
            out_data_r.out_capacity  <= rd_data.capacity;
            out_data_r.last_result   <= (idx_inc == cnt_r);
            idx_r                    <= idx_inc;
            if (idx_inc == cnt_r) begin
              cnt_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_CLR_RD;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r              <= 1'b1;
            out_data_r.result_kind   <= res_kind_r;
            out_data_r.out_handle    <= res_h_r;
            out_data_r.out_capacity  <= res_c_r;
            out_data_r.last_result   <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/bfbp_checker.sv
// port-level checks for the best-fit buffer pool, bound to the top level
module bfbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bfbp_pkg::out_item_t out_data
);
  import bfbp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: an input transfer is followed by a stalled input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // only a clear produces more than one result, and those are all freed buffers
  a_not_last_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> out_data.result_kind == KIND_FREED)
    else $error("non-final result that is not a freed buffer");

  // allocate and nothing results carry zero handles
  a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_ALLOC ||
                  out_data.result_kind == KIND_NOTHING) |-> out_data.out_handle == '0)
    else $error("nonzero handle on allocate or nothing result");

  a_nothing_zero_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_NOTHING |-> out_data.out_capacity == '0)
    else $error("nonzero capacity on nothing result");

endmodule

bind best_fit_buffer_pool_unit bfbp_checker u_bfbp_checker (.*);

>>> tb/sv/tb_top.sv
// self-checking testbench for the best-fit buffer pool unit
module tb_top;
  import bfbp_pkg::*;

  localparam int POOL_DEPTH = 8;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 280;
  localparam int QUIET_TAIL = 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_items[$];
  out_item_t owed_results[$];
  entry_t    pool[POOL_DEPTH];
  int        pool_fill = 0;
  int        errors = 0;
  int        in_gap = 0;
  int        stall_left = 0;

  best_fit_buffer_pool_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic void owe(logic [1:0] kind, logic [HANDLE_W-1:0] handle,
                              logic [CAP_W-1:0] capacity, logic last);
    out_item_t r;
    r.result_kind  = kind;
    r.out_handle   = handle;
    r.out_capacity = capacity;
    r.last_result  = last;
    owed_results.push_back(r);
  endfunction

  // updates the pool copy and queues the results one accepted item causes
  function automatic void apply_pool_action(in_item_t it);
    int     best;
    bit     have;
    bit     evicting;
    int     keep;
    entry_t gone;
    have = 1'b0;
    best = 0;
    unique case (it.action)
      ACT_REQUEST: begin
        for (int i = 0; i < pool_fill; i++) begin
          if (pool[i].capacity == it.request_size) begin
            best = i;
            have = 1'b1;
            break;
          end
          if (pool[i].capacity > it.request_size &&
              (!have || pool[i].capacity < pool[best].capacity)) begin
            best = i;
            have = 1'b1;
          end
        end
        if (have) begin
          gone = pool[best];
          for (int i = best; i < pool_fill - 1; i++) pool[i] = pool[i + 1];
          pool_fill--;
          owe(KIND_POOLED, gone.handle, gone.capacity, 1'b1);
        end else begin
          owe(KIND_ALLOC, '0, it.request_size, 1'b1);
        end
      end
      ACT_RETURN: begin
        evicting = (pool_fill >= POOL_DEPTH);
        gone = pool[POOL_DEPTH - 1];
        keep = evicting ? POOL_DEPTH - 1 : pool_fill;
        for (int i = keep; i > 0; i--) pool[i] = pool[i - 1];
        pool[0].handle   = it.returned_handle;
        pool[0].capacity = it.returned_capacity;
        pool_fill = keep + 1;
        if (evicting) owe(KIND_FREED, gone.handle, gone.capacity, 1'b1);
        else owe(KIND_NOTHING, '0, '0, 1'b1);
      end
      ACT_CLEAR: begin
        if (pool_fill == 0) owe(KIND_NOTHING, '0, '0, 1'b1);
        for (int i = 0; i < pool_fill; i++)
          owe(KIND_FREED, pool[i].handle, pool[i].capacity, i == pool_fill - 1);
        pool_fill = 0;
      end
      default: owe(KIND_NOTHING, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] action, logic [CAP_W-1:0] size,
                                     logic [HANDLE_W-1:0] handle, logic [CAP_W-1:0] cap);
    in_item_t it;
    it.action            = action;
    it.request_size      = size;
    it.returned_handle   = handle;
    it.returned_capacity = cap;
    pending_items.push_back(it);
  endfunction

  // mostly a few recurring sizes so that exact and best-fit hits happen often
  function automatic logic [CAP_W-1:0] pick_capacity();
    logic [CAP_W-1:0] sizes[9];
    sizes = '{24'd0, 24'd1, 24'd16, 24'd100, 24'd256, 24'd4096, 24'd65535,
              24'h800000, 24'hFFFFFF};
    if ($urandom_range(0, 3) == 0) return CAP_W'($urandom);
    return sizes[$urandom_range(0, 8)];
  endfunction

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want_v, got_v);
      errors++;
    end
  endtask

  // input driver: valid stays up through a stall, gaps start right after a transfer
  always @(posedge clk) begin : drive_in
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid && pending_items.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 13);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rst_n && pending_items.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_pool_action(in_data);
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: expected no result, actual %h", $time, out_data);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
          check_field("out_handle", 32'(want.out_handle), 32'(out_data.out_handle));
          check_field("out_capacity", 32'(want.out_capacity), 32'(out_data.out_capacity));
          check_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
        end
      end
    end
  end

  initial begin : run
    int counted;
    int roll;
    // misses on an empty pool, empty clear, unused code, then two returns
    queue_item(ACT_REQUEST, 24'd0, 16'hFFFF, 24'hFFFFFF);
    queue_item(ACT_REQUEST, 24'hFFFFFF, 16'h0, 24'h0);
    queue_item(ACT_CLEAR, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
    queue_item(ACT_UNUSED, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
    queue_item(ACT_RETURN, 24'd0, 16'hFFFF, 24'hFFFFFF);
    queue_item(ACT_RETURN, 24'hFFFFFF, 16'h0, 24'd0);
    // zero size hits the zero-capacity entry, then a larger one
    queue_item(ACT_REQUEST, 24'd0, 16'h0, 24'd0);
    queue_item(ACT_REQUEST, 24'd5, 16'h0, 24'd0);
    // fill the pool, then overflow it
    queue_item(ACT_RETURN, 24'd0, 16'd1, 24'd300);
    queue_item(ACT_RETURN, 24'd0, 16'd2, 24'd100);
    queue_item(ACT_RETURN, 24'd0, 16'd3, 24'd200);
    queue_item(ACT_RETURN, 24'd0, 16'd4, 24'd100);
    queue_item(ACT_RETURN, 24'd0, 16'd5, 24'd500);
    queue_item(ACT_RETURN, 24'd0, 16'd6, 24'd100);
    queue_item(ACT_RETURN, 24'd0, 16'd7, 24'd50);
    queue_item(ACT_RETURN, 24'd0, 16'd8, 24'd700);
    queue_item(ACT_RETURN, 24'd0, 16'd9, 24'd100);
    // tie among larger entries, exact match, smallest larger, miss
    queue_item(ACT_REQUEST, 24'd60, 16'h0, 24'd0);
    queue_item(ACT_REQUEST, 24'd100, 16'h0, 24'd0);
    queue_item(ACT_REQUEST, 24'd150, 16'h0, 24'd0);
    queue_item(ACT_RETURN, 24'd0, 16'd10, 24'h800000);
    queue_item(ACT_REQUEST, 24'h7FFFFF, 16'h0, 24'd0);
    queue_item(ACT_REQUEST, 24'hFFFFFF, 16'h0, 24'd0);
    // back to full, then clear it
    queue_item(ACT_RETURN, 24'd0, 16'd11, 24'd0);
    queue_item(ACT_RETURN, 24'd0, 16'hAAAA, 24'h555555);
    queue_item(ACT_RETURN, 24'd0, 16'h5555, 24'hAAAAAA);
    queue_item(ACT_CLEAR, 24'd0, 16'h0, 24'd0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        queue_item(ACT_REQUEST, pick_capacity(), 16'($urandom), 24'($urandom));
        counted++;
      end else if (roll < 89) begin
        queue_item(ACT_RETURN, 24'($urandom), 16'($urandom), pick_capacity());
        counted++;
      end else if (roll < 96) begin
        queue_item(ACT_CLEAR, 24'($urandom), 16'($urandom), 24'($urandom));
        counted++;
      end else begin
        queue_item(ACT_UNUSED, 24'($urandom), 16'($urandom), 24'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("best_fit_buffer_pool_unit: match");
    end else begin
      $display("best_fit_buffer_pool_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("best_fit_buffer_pool_unit: mismatch");
    $finish;
  end

endmodule
